FILE: sv/dsbp_pkg.sv
`default_nettype none

package dsbp_pkg;

   // Grid and field widths
   localparam int GRID_SIZE  = 256;
   localparam int IDX_W      = 10;
   localparam int CHG_W      = 24;
   localparam int COORD_W    = 20;
   localparam int COORD_FRAC = 8;
   localparam int CTR_W      = 3 * COORD_W;
   localparam int IGS_W      = 20;
   localparam int IDL_W      = 20;
   localparam int IEPS_W     = 24;
   localparam int POT_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CTR_W;

   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(GRID_SIZE - 1);

   // Datapath widths
   localparam int POS_W   = IDX_W + 1 + COORD_FRAC;   // (index + 1) * 256
   localparam int D_W     = POS_W + 2;                // signed axis difference
   localparam int AD_W    = D_W - 1;                  // magnitude of the difference
   localparam int SQ_W    = 2 * AD_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int G_W     = SUM_W / 2;                // root of the squared distance
   localparam int REM_W   = G_W + 2;
   localparam int R_W     = G_W + IGS_W - 8;          // distance, Q.16
   localparam int X_W     = R_W + IDL_W - 16;
   localparam int L2E_W   = 17;
   localparam int Y_W     = X_W + L2E_W - 16;
   localparam int FRAC_W  = 16;
   localparam int N_W     = Y_W - FRAC_W;
   localparam int E_W     = 31;
   localparam int E_FRAC  = 30;
   localparam int A_W     = CHG_W;
   localparam int NUM_W   = A_W + IEPS_W;
   localparam int DIV_DROP = 8;
   localparam int T_W     = NUM_W - DIV_DROP;
   localparam int S_W     = T_W + 2;
   localparam int EXP_MAX_SHIFT = 30;

   localparam logic [L2E_W-1:0] LOG2E_Q16 = L2E_W'(94548);
   localparam logic [E_W-1:0]   ONE_Q30   = E_W'(1) << E_FRAC;

   localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
   localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

   // Pipeline depth of one charge term
   localparam int SQRT_STAGES = G_W;
   localparam int EXP_STAGES  = FRAC_W;
   localparam int DIV_STAGES  = NUM_W;
   localparam int TERM_LAT    = 3 + SQRT_STAGES + 3 + EXP_STAGES + 3 + DIV_STAGES;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLUS_CHARGE   = 3'd0,
      CSR_MINUS_CHARGE  = 3'd1,
      CSR_PLUS_CENTER   = 3'd2,
      CSR_MINUS_CENTER  = 3'd3,
      CSR_INV_GRID      = 3'd4,
      CSR_INV_DEBYE     = 3'd5,
      CSR_INV_EPS       = 3'd6
   } csr_index_type;

   // Grid coordinate of each point axis, Q.8
   typedef struct packed {
      logic [2:0][POS_W-1:0] pos;
   } point_type;

   // Settings shared by both charge terms
   typedef struct packed {
      logic [IGS_W-1:0]  inv_grid;
      logic [IDL_W-1:0]  inv_debye;
      logic [IEPS_W-1:0] inv_eps;
   } shared_cfg_type;

   // Result of one charge term
   typedef struct packed {
      logic             zero;
      logic [NUM_W-1:0] quo;
   } term_out_type;

   // Roots of two: c_k = 2^(-2^-k) in Q.30
   typedef logic [EXP_STAGES:0][E_W-1:0] root_tab_type;

   function automatic logic [63:0] isqrt_const(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] rem;
      r   = '0;
      rem = v;
      b   = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic root_tab_type calc_root_tab();
      root_tab_type tab;
      logic [63:0]  c;
      c      = 64'h1 << (E_FRAC - 1);
      tab[0] = E_W'(c);
      for (int k = 1; k <= EXP_STAGES; k++) begin
         c      = isqrt_const(c << E_FRAC);
         tab[k] = E_W'(c);
      end
      return tab;
   endfunction

   localparam root_tab_type ROOT_TAB = calc_root_tab();

   // Saturate an index to the grid and scale to a Q.8 coordinate
   function automatic logic [POS_W-1:0] grid_pos(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] sat;
      logic [IDX_W:0]   p1;
      sat = (idx > IDX_MAX) ? IDX_MAX : idx;
      p1  = (IDX_W+1)'(sat) + (IDX_W+1)'(1);
      return {p1, {COORD_FRAC{1'b0}}};
   endfunction

endpackage

`default_nettype wire

FILE: sv/dsbp_chan_if.sv
`default_nettype none

interface dsbp_req_if;
   logic                        valid;
   logic                        ready;
   logic [dsbp_pkg::IDX_W-1:0]  index_x;
   logic [dsbp_pkg::IDX_W-1:0]  index_y;
   logic [dsbp_pkg::IDX_W-1:0]  index_z;
   modport source (output valid, output index_x, output index_y, output index_z, input ready);
   modport sink   (input valid, input index_x, input index_y, input index_z, output ready);
endinterface

interface dsbp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [dsbp_pkg::POT_W-1:0] potential;
   logic                              overflow;
   modport source (output valid, output potential, output overflow, input ready);
   modport sink   (input valid, input potential, input overflow, output ready);
endinterface

interface dsbp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [dsbp_pkg::CSR_IDX_W-1:0]    index;
   logic [dsbp_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dsbp_term.sv
`default_nettype none

module dsbp_term (
   input  logic                                clock,
   input  logic                                advance,
   input  dsbp_pkg::point_type                 point,
   input  logic [dsbp_pkg::CTR_W-1:0]          center,
   input  logic signed [dsbp_pkg::CHG_W-1:0]   charge,
   input  dsbp_pkg::shared_cfg_type            cfg,
   output dsbp_pkg::term_out_type              res
);

   localparam int COORD_W  = dsbp_pkg::COORD_W;
   localparam int D_W      = dsbp_pkg::D_W;
   localparam int AD_W     = dsbp_pkg::AD_W;
   localparam int SQ_W     = dsbp_pkg::SQ_W;
   localparam int SUM_W    = dsbp_pkg::SUM_W;
   localparam int G_W      = dsbp_pkg::G_W;
   localparam int REM_W    = dsbp_pkg::REM_W;
   localparam int R_W      = dsbp_pkg::R_W;
   localparam int X_W      = dsbp_pkg::X_W;
   localparam int Y_W      = dsbp_pkg::Y_W;
   localparam int FRAC_W   = dsbp_pkg::FRAC_W;
   localparam int N_W      = dsbp_pkg::N_W;
   localparam int E_W      = dsbp_pkg::E_W;
   localparam int E_FRAC   = dsbp_pkg::E_FRAC;
   localparam int A_W      = dsbp_pkg::A_W;
   localparam int NUM_W    = dsbp_pkg::NUM_W;
   localparam int SQRT_N   = dsbp_pkg::SQRT_STAGES;
   localparam int EXP_N    = dsbp_pkg::EXP_STAGES;
   localparam int DIV_N    = dsbp_pkg::DIV_STAGES;
   localparam int RG_W     = G_W + dsbp_pkg::IGS_W;
   localparam int RX_W     = R_W + dsbp_pkg::IDL_W;
   localparam int XY_W     = X_W + dsbp_pkg::L2E_W;
   localparam int EP_W     = 2 * E_W;
   localparam int AP_W     = A_W + E_W;

   // Axis differences and their magnitudes
   logic signed [D_W-1:0] d_w [3];
   logic [AD_W-1:0]       ad_in [3];
   logic [AD_W-1:0]       ad_ff [3];
   logic [SQ_W-1:0]       sq_ff [3];
   logic [SUM_W-1:0]      sum_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d_w[a]   = D_W'(signed'(center[a*COORD_W +: COORD_W]))
                    - signed'(D_W'(point.pos[a]));
         ad_in[a] = d_w[a][D_W-1] ? AD_W'(-d_w[a]) : AD_W'(d_w[a]);
      end
   end

   // Square each axis, then sum
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            ad_ff[a] <= ad_in[a];
            sq_ff[a] <= SQ_W'(ad_ff[a]) * SQ_W'(ad_ff[a]);
         end
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      end
   end

   // Integer square root, one result bit per stage
   logic [SUM_W-1:0] sv_ff    [SQRT_N];
   logic [REM_W-1:0] srem_ff  [SQRT_N];
   logic [G_W-1:0]   sroot_ff [SQRT_N];
   logic [SUM_W-1:0] sv_ch    [SQRT_N+1];
   logic [REM_W-1:0] srem_ch  [SQRT_N+1];
   logic [G_W-1:0]   sroot_ch [SQRT_N+1];

   assign sv_ch[0]    = sum_ff;
   assign srem_ch[0]  = '0;
   assign sroot_ch[0] = '0;

   for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
      logic [REM_W+1:0] rem2_w;
      logic [REM_W+1:0] trial_w;
      logic             take_w;

      assign rem2_w  = {srem_ch[i], sv_ch[i][SUM_W-1 -: 2]};
      assign trial_w = (REM_W+2)'({sroot_ch[i], 2'b01});
      assign take_w  = rem2_w >= trial_w;

      always_ff @(posedge clock) begin
         if (advance) begin
            sv_ff[i]    <= {sv_ch[i][SUM_W-3:0], 2'b00};
            srem_ff[i]  <= take_w ? REM_W'(rem2_w - trial_w) : REM_W'(rem2_w);
            sroot_ff[i] <= {sroot_ch[i][G_W-2:0], take_w};
         end
      end

      assign sv_ch[i+1]    = sv_ff[i];
      assign srem_ch[i+1]  = srem_ff[i];
      assign sroot_ch[i+1] = sroot_ff[i];
   end

   // Distance, scaled distance and base-two exponent
   logic [R_W-1:0] r_ff;
   logic [R_W-1:0] rx_ff;
   logic [R_W-1:0] ry_ff;
   logic [X_W-1:0] x_ff;
   logic [Y_W-1:0] y_ff;
   logic [RG_W-1:0] rg_w;
   logic [RX_W-1:0] rx_w;
   logic [XY_W-1:0] xy_w;

   assign rg_w = RG_W'(sroot_ch[SQRT_N]) * RG_W'(cfg.inv_grid);
   assign rx_w = RX_W'(r_ff) * RX_W'(cfg.inv_debye);
   assign xy_w = XY_W'(x_ff) * XY_W'(dsbp_pkg::LOG2E_Q16);

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff  <= R_W'(rg_w >> 8);
         x_ff  <= X_W'(rx_w >> 16);
         rx_ff <= r_ff;
         y_ff  <= Y_W'(xy_w >> 16);
         ry_ff <= rx_ff;
      end
   end

   // Fractional power of two, one root factor per stage
   logic [E_W-1:0]    e_ff [EXP_N];
   logic [FRAC_W-1:0] f_ff [EXP_N];
   logic [N_W-1:0]    n_ff [EXP_N];
   logic [R_W-1:0]    re_ff [EXP_N];
   logic [E_W-1:0]    e_ch [EXP_N+1];
   logic [FRAC_W-1:0] f_ch [EXP_N+1];
   logic [N_W-1:0]    n_ch [EXP_N+1];
   logic [R_W-1:0]    re_ch [EXP_N+1];

   assign e_ch[0]  = dsbp_pkg::ONE_Q30;
   assign f_ch[0]  = y_ff[FRAC_W-1:0];
   assign n_ch[0]  = y_ff[Y_W-1:FRAC_W];
   assign re_ch[0] = ry_ff;

   for (genvar j = 0; j < EXP_N; j++) begin : g_exp
      logic [EP_W-1:0] prod_w;

      assign prod_w = EP_W'(e_ch[j]) * EP_W'(dsbp_pkg::ROOT_TAB[j+1]);

      always_ff @(posedge clock) begin
         if (advance) begin
            e_ff[j]  <= f_ch[j][FRAC_W-1-j] ? E_W'(prod_w >> E_FRAC) : e_ch[j];
            f_ff[j]  <= f_ch[j];
            n_ff[j]  <= n_ch[j];
            re_ff[j] <= re_ch[j];
         end
      end

      assign e_ch[j+1]  = e_ff[j];
      assign f_ch[j+1]  = f_ff[j];
      assign n_ch[j+1]  = n_ff[j];
      assign re_ch[j+1] = re_ff[j];
   end

   // Integer power, charge product and dielectric product
   logic [E_W-1:0]   es_ff;
   logic [A_W-1:0]   a_ff;
   logic [NUM_W-1:0] num_ff;
   logic [R_W-1:0]   rs_ff;
   logic [R_W-1:0]   ra_ff;
   logic [R_W-1:0]   rn_ff;
   logic [A_W-1:0]   mag_w;
   logic [AP_W-1:0]  ap_w;

   assign mag_w = charge[dsbp_pkg::CHG_W-1] ? A_W'(-charge) : A_W'(charge);
   assign ap_w  = AP_W'(mag_w) * AP_W'(es_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         es_ff  <= (n_ch[EXP_N] > N_W'(dsbp_pkg::EXP_MAX_SHIFT)) ? '0
                   : e_ch[EXP_N] >> n_ch[EXP_N][4:0];
         rs_ff  <= re_ch[EXP_N];
         a_ff   <= A_W'(ap_w >> E_FRAC);
         ra_ff  <= rs_ff;
         num_ff <= NUM_W'(a_ff) * NUM_W'(cfg.inv_eps);
         rn_ff  <= ra_ff;
      end
   end

   // Restoring division by the distance, one quotient bit per stage
   logic [NUM_W-1:0] dn_ff   [DIV_N];
   logic [R_W-1:0]   drem_ff [DIV_N];
   logic [R_W-1:0]   dr_ff   [DIV_N];
   logic [NUM_W-1:0] dn_ch   [DIV_N+1];
   logic [R_W-1:0]   drem_ch [DIV_N+1];
   logic [R_W-1:0]   dr_ch   [DIV_N+1];

   assign dn_ch[0]   = num_ff;
   assign drem_ch[0] = '0;
   assign dr_ch[0]   = rn_ff;

   for (genvar i = 0; i < DIV_N; i++) begin : g_div
      logic [R_W:0] rem2_w;
      logic [R_W:0] dvs_w;
      logic         take_w;

      assign rem2_w = {drem_ch[i], dn_ch[i][NUM_W-1]};
      assign dvs_w  = {1'b0, dr_ch[i]};
      assign take_w = rem2_w >= dvs_w;

      always_ff @(posedge clock) begin
         if (advance) begin
            drem_ff[i] <= take_w ? R_W'(rem2_w - dvs_w) : R_W'(rem2_w);
            dn_ff[i]   <= {dn_ch[i][NUM_W-2:0], take_w};
            dr_ff[i]   <= dr_ch[i];
         end
      end

      assign dn_ch[i+1]   = dn_ff[i];
      assign drem_ch[i+1] = drem_ff[i];
      assign dr_ch[i+1]   = dr_ff[i];
   end

   assign res.zero = (dr_ch[DIV_N] == '0);
   assign res.quo  = dn_ch[DIV_N];

endmodule

`default_nettype wire

FILE: sv/dipole_screened_boundary_potential_core.sv
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    index_x, index_y, index_z (10 bits each)
// rsp      out  valid/ready    potential (signed 32), overflow
// csr      in   valid/ready    index (3 bits), data (60 bits)
//
// One grid point enters per cycle unless a held result stalls the pipeline; each term
// computes it through the 21-stage square root, 16-stage exponential and 48-stage divider.
// Reset is synchronous: it empties the pipeline and loads the register defaults.
// A held result freezes the whole pipeline; req ready drops only then.
// Register writes are always taken and reach points already in flight, so writes must
// go in only while the pipeline is empty; the block itself does not enforce this.
`default_nettype none

module dipole_screened_boundary_potential_core (
   input  logic       clock,
   input  logic       reset,
   dsbp_req_if.sink   req_chan,
   dsbp_rsp_if.source rsp_chan,
   dsbp_csr_if.sink   csr_chan
);

   localparam int LAST   = dsbp_pkg::TERM_LAT;
   localparam int CHG_W  = dsbp_pkg::CHG_W;
   localparam int CTR_W  = dsbp_pkg::CTR_W;
   localparam int NUM_W  = dsbp_pkg::NUM_W;
   localparam int T_W    = dsbp_pkg::T_W;
   localparam int S_W    = dsbp_pkg::S_W;
   localparam int POT_W  = dsbp_pkg::POT_W;
   localparam int DROP   = dsbp_pkg::DIV_DROP;

   // Configuration registers
   logic signed [CHG_W-1:0]          plus_charge_ff;
   logic signed [CHG_W-1:0]          minus_charge_ff;
   logic [CTR_W-1:0]                 plus_center_ff;
   logic [CTR_W-1:0]                 minus_center_ff;
   logic [dsbp_pkg::IGS_W-1:0]       inv_grid_ff;
   logic [dsbp_pkg::IDL_W-1:0]       inv_debye_ff;
   logic [dsbp_pkg::IEPS_W-1:0]      inv_eps_ff;
   dsbp_pkg::csr_index_type          csr_idx_w;
   logic                             csr_xfer_w;

   assign csr_chan.ready = 1'b1;
   assign csr_xfer_w     = csr_chan.valid && csr_chan.ready;
   assign csr_idx_w      = dsbp_pkg::csr_index_type'(csr_chan.index);

   // Decode register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         plus_charge_ff  <= '0;
         minus_charge_ff <= '0;
         plus_center_ff  <= '0;
         minus_center_ff <= '0;
         inv_grid_ff     <= dsbp_pkg::IGS_W'(65536);
         inv_debye_ff    <= '0;
         inv_eps_ff      <= dsbp_pkg::IEPS_W'(209715);
      end else if (csr_xfer_w) begin
         unique case (csr_idx_w)
            dsbp_pkg::CSR_PLUS_CHARGE:  plus_charge_ff  <= CHG_W'(csr_chan.data);
            dsbp_pkg::CSR_MINUS_CHARGE: minus_charge_ff <= CHG_W'(csr_chan.data);
            dsbp_pkg::CSR_PLUS_CENTER:  plus_center_ff  <= CTR_W'(csr_chan.data);
            dsbp_pkg::CSR_MINUS_CENTER: minus_center_ff <= CTR_W'(csr_chan.data);
            dsbp_pkg::CSR_INV_GRID:     inv_grid_ff  <= dsbp_pkg::IGS_W'(csr_chan.data);
            dsbp_pkg::CSR_INV_DEBYE:    inv_debye_ff <= dsbp_pkg::IDL_W'(csr_chan.data);
            dsbp_pkg::CSR_INV_EPS:      inv_eps_ff   <= dsbp_pkg::IEPS_W'(csr_chan.data);
            default: ;
         endcase
      end
   end

   // Pipeline control: valid bits advance unless the result is held
   logic [LAST:0] vld_ff;
   logic [LAST:0] vld_in;
   logic          advance_w;
   logic          req_xfer_w;

   assign advance_w      = !(vld_ff[LAST] && !rsp_chan.ready);
   assign req_chan.ready = advance_w;
   assign req_xfer_w     = req_chan.valid && advance_w;
   assign vld_in         = {vld_ff[LAST-1:0], req_xfer_w};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance_w) begin
         vld_ff <= vld_in;
      end
   end

   // Grid coordinates of the incoming point
   dsbp_pkg::point_type      point_w;
   dsbp_pkg::shared_cfg_type cfg_w;

   assign point_w.pos[0] = dsbp_pkg::grid_pos(req_chan.index_x);
   assign point_w.pos[1] = dsbp_pkg::grid_pos(req_chan.index_y);
   assign point_w.pos[2] = dsbp_pkg::grid_pos(req_chan.index_z);

   assign cfg_w.inv_grid  = inv_grid_ff;
   assign cfg_w.inv_debye = inv_debye_ff;
   assign cfg_w.inv_eps   = inv_eps_ff;

   dsbp_pkg::term_out_type plus_res_w;
   dsbp_pkg::term_out_type minus_res_w;

   dsbp_term u_plus (
      .clock   (clock),
      .advance (advance_w),
      .point   (point_w),
      .center  (plus_center_ff),
      .charge  (plus_charge_ff),
      .cfg     (cfg_w),
      .res     (plus_res_w)
   );

   dsbp_term u_minus (
      .clock   (clock),
      .advance (advance_w),
      .point   (point_w),
      .center  (minus_center_ff),
      .charge  (minus_charge_ff),
      .cfg     (cfg_w),
      .res     (minus_res_w)
   );

   // Sign the terms, sum and saturate
   logic [T_W-1:0]          tp_w;
   logic [T_W-1:0]          tm_w;
   logic signed [S_W-1:0]   sp_w;
   logic signed [S_W-1:0]   sm_w;
   logic signed [S_W-1:0]   sum_w;
   logic signed [POT_W-1:0] pot_in;
   logic                    ovf_in;
   logic signed [POT_W-1:0] pot_ff;
   logic                    ovf_ff;
   logic signed [CHG_W-1:0] zq_w;

   assign tp_w  = plus_res_w.quo[NUM_W-1:DROP];
   assign tm_w  = minus_res_w.quo[NUM_W-1:DROP];
   assign sp_w  = plus_charge_ff[CHG_W-1] ? -signed'(S_W'(tp_w)) : signed'(S_W'(tp_w));
   assign sm_w  = minus_charge_ff[CHG_W-1] ? -signed'(S_W'(tm_w)) : signed'(S_W'(tm_w));
   assign sum_w = sp_w + sm_w;
   assign zq_w  = plus_res_w.zero ? plus_charge_ff : minus_charge_ff;

   always_comb begin
      if (plus_res_w.zero || minus_res_w.zero) begin
         pot_in = zq_w[CHG_W-1] ? dsbp_pkg::POT_MIN : dsbp_pkg::POT_MAX;
         ovf_in = 1'b1;
      end else if (sum_w > S_W'(dsbp_pkg::POT_MAX)) begin
         pot_in = dsbp_pkg::POT_MAX;
         ovf_in = 1'b1;
      end else if (sum_w < S_W'(dsbp_pkg::POT_MIN)) begin
         pot_in = dsbp_pkg::POT_MIN;
         ovf_in = 1'b1;
      end else begin
         pot_in = POT_W'(sum_w);
         ovf_in = 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (advance_w) begin
         pot_ff <= pot_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_chan.valid     = vld_ff[LAST];
   assign rsp_chan.potential = pot_ff;
   assign rsp_chan.overflow  = ovf_ff;

endmodule

`default_nettype wire

FILE: sv/dsbp_checker.sv
`default_nettype none

module dsbp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [dsbp_pkg::POT_W-1:0] rsp_potential,
   input logic                              rsp_overflow,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   // Input stalls only behind a held result
   a_req_stall: assert property (@(posedge clock)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req ready low without a held result");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_potential) && $stable(rsp_overflow)))
      else $error("held result changed");

   // Register writes are never refused
   a_csr_ready: assert property (@(posedge clock)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind dipole_screened_boundary_potential_core dsbp_checker u_dsbp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_potential (rsp_chan.potential),
   .rsp_overflow  (rsp_chan.overflow),
   .csr_valid     (csr_chan.valid),
   .csr_ready     (csr_chan.ready)
);

`default_nettype wire

FILE: bench/dsbp_potential_checker.sv
`timescale 1ns / 100ps

module dsbp_potential_checker (
   input  logic  clock,
   input  logic  reset,
   dsbp_req_if   req,
   dsbp_rsp_if   rsp,
   dsbp_csr_if   csr,
   output int    fail_count,
   output int    pending_count
);
   import dsbp_pkg::*;

   typedef struct {
      logic signed [POT_W-1:0] potential;
      logic                    overflow;
   } potential_result_type;

   // Register copy kept in step with the write channel
   logic signed [CHG_W-1:0] plus_q, minus_q;
   logic [CTR_W-1:0]        plus_ctr, minus_ctr;
   logic [IGS_W-1:0]        inv_grid;
   logic [IDL_W-1:0]        inv_debye;
   logic [IEPS_W-1:0]       inv_eps;

   longint unsigned       exp_roots [0:16];
   potential_result_type  awaited_potentials [$];

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r, b, rem;
      r   = 0;
      rem = v;
      b   = 64'h1 << 62;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r   = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Distance in angstrom, Q.16, from a packed center to a Q.8 point
   function automatic longint unsigned center_distance(input logic [CTR_W-1:0] ctr,
                                                       input longint unsigned pos [3]);
      longint unsigned sum;
      longint          d;
      sum = 0;
      for (int a = 0; a < 3; a++) begin
         d = longint'(signed'(ctr[COORD_W*a +: COORD_W])) - longint'(pos[a]);
         if (d < 0) d = -d;
         sum += longint'(d) * longint'(d);
      end
      return (floor_root(sum) * longint'(inv_grid)) >> 8;
   endfunction

   function automatic longint screened_term(input longint q, input longint unsigned r);
      longint unsigned x, y, n, f, e, mag, a, t;
      x = (r * inv_debye) >> 16;
      y = (x * 94548) >> 16;
      n = y >> 16;
      f = y & 16'hFFFF;
      e = 64'h1 << 30;
      for (int k = 1; k <= 16; k++)
         if ((f >> (16 - k)) & 1) e = (e * exp_roots[k]) >> 30;
      e   = (n > 30) ? 0 : (e >> n);
      mag = (q < 0) ? -q : q;
      a   = (mag * e) >> 30;
      t   = ((a * inv_eps) / r) >> 8;
      return (q < 0) ? -longint'(t) : longint'(t);
   endfunction

   function automatic potential_result_type predict_potential(input logic [IDX_W-1:0] ix,
                                                              input logic [IDX_W-1:0] iy,
                                                              input logic [IDX_W-1:0] iz);
      potential_result_type res;
      longint unsigned      pos [3];
      logic [IDX_W-1:0]     idx [3];
      longint unsigned      rp, rm;
      longint               q, sum;
      idx[0] = ix;
      idx[1] = iy;
      idx[2] = iz;
      for (int a = 0; a < 3; a++)
         pos[a] = ((idx[a] > GRID_SIZE - 1 ? GRID_SIZE - 1 : idx[a]) + 1) * 256;
      rp = center_distance(plus_ctr, pos);
      rm = center_distance(minus_ctr, pos);
      if (rp == 0 || rm == 0) begin
         q = (rp == 0) ? longint'(plus_q) : longint'(minus_q);
         res.potential = (q < 0) ? POT_MIN : POT_MAX;
         res.overflow  = 1'b1;
         return res;
      end
      sum = screened_term(plus_q, rp) + screened_term(minus_q, rm);
      res.overflow = 1'b0;
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647;
         res.overflow = 1'b1;
      end
      if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648;
         res.overflow = 1'b1;
      end
      res.potential = sum[POT_W-1:0];
      return res;
   endfunction

   initial begin
      exp_roots[0] = 64'h1 << 29;
      for (int k = 1; k <= 16; k++) exp_roots[k] = floor_root(exp_roots[k-1] << 30);
   end

   assign pending_count = awaited_potentials.size();

   always @(posedge clock) begin
      potential_result_type got, want;
      if (reset) begin
         plus_q    <= '0;
         minus_q   <= '0;
         plus_ctr  <= '0;
         minus_ctr <= '0;
         inv_grid  <= IGS_W'(65536);
         inv_debye <= '0;
         inv_eps   <= IEPS_W'(209715);
         awaited_potentials.delete();
      end else begin
         // Track register writes; unknown indexes are dropped
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_PLUS_CHARGE:  plus_q    <= csr.data[CHG_W-1:0];
               CSR_MINUS_CHARGE: minus_q   <= csr.data[CHG_W-1:0];
               CSR_PLUS_CENTER:  plus_ctr  <= csr.data[CTR_W-1:0];
               CSR_MINUS_CENTER: minus_ctr <= csr.data[CTR_W-1:0];
               CSR_INV_GRID:     inv_grid  <= csr.data[IGS_W-1:0];
               CSR_INV_DEBYE:    inv_debye <= csr.data[IDL_W-1:0];
               CSR_INV_EPS:      inv_eps   <= csr.data[IEPS_W-1:0];
               default: ;
            endcase
         end
         // Predict each accepted grid point
         if (req.valid && req.ready)
            awaited_potentials.push_back(predict_potential(req.index_x, req.index_y,
                                                           req.index_z));
         // Compare each result transfer with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            got.potential = rsp.potential;
            got.overflow  = rsp.overflow;
            if (awaited_potentials.size() == 0) begin
               $error("unexpected result: potential %0d overflow %0b",
                      got.potential, got.overflow);
               fail_count++;
            end else begin
               want = awaited_potentials.pop_front();
               if (got.potential !== want.potential) begin
                  $error("potential: expected %0d, actual %0d", want.potential,
                         got.potential);
                  fail_count++;
               end
               if (got.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, actual %0b", want.overflow,
                         got.overflow);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: bench/dipole_screened_boundary_potential_core_test.sv
`timescale 1ns / 100ps

module dipole_screened_boundary_potential_core_test;
   import dsbp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;
   localparam int DRAIN_CYCLES = 120;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;

   logic clock;
   logic reset;
   int   fail_count, pending_count;
   int   idle_pct, stall_pct, hold_left, quiet_cycles, points_sent, config_writes;
   bit   hold_req, hold_taken;
   int   plus_cell [3], minus_cell [3];

   dsbp_req_if req ();
   dsbp_rsp_if rsp ();
   dsbp_csr_if csr ();

   dipole_screened_boundary_potential_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   dsbp_potential_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .csr           (csr),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      config_writes++;
   endtask

   task automatic send_point(input int x, input int y, input int z);
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.index_x <= IDX_W'(x);
      req.index_y <= IDX_W'(y);
      req.index_z <= IDX_W'(z);
      do @(posedge clock); while (!req.ready);
      points_sent++;
   endtask

   // Hold until every result is in, then let the pipeline empty
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CTR_W-1:0] pack_center(input int c [3]);
      logic [CTR_W-1:0] v;
      for (int a = 0; a < 3; a++) v[COORD_W*a +: COORD_W] = COORD_W'(c[a]);
      return v;
   endfunction

   // Center on a grid point (grid index) or anywhere in the coordinate range
   task automatic place_center(output logic [CTR_W-1:0] packed_ctr, output int grid_idx [3]);
      int c [3];
      bit on_grid;
      on_grid = $urandom_range(1);
      for (int a = 0; a < 3; a++) begin
         grid_idx[a] = $urandom_range(GRID_SIZE - 1);
         c[a] = on_grid ? (grid_idx[a] + 1) * 256 : int'($urandom_range(20'hFFFFF));
         if (!on_grid) grid_idx[a] = (c[a] < 20'h80000) ? c[a] / 256 : 0;
      end
      packed_ctr = pack_center(c);
   endtask

   task automatic random_settings(input int phase);
      logic [CTR_W-1:0] ctr;
      write_reg(CSR_PLUS_CHARGE, CSR_DATA_W'($urandom_range(24'hFFFFFF)));
      write_reg(CSR_MINUS_CHARGE, CSR_DATA_W'($urandom_range(24'hFFFFFF)));
      place_center(ctr, plus_cell);
      write_reg(CSR_PLUS_CENTER, ctr);
      place_center(ctr, minus_cell);
      write_reg(CSR_MINUS_CENTER, ctr);
      case (phase % 4)
         0: write_reg(CSR_INV_GRID, 20'hFFFFF);
         1: write_reg(CSR_INV_GRID, 20'd1);
         default: write_reg(CSR_INV_GRID, $urandom_range(8192, 262144));
      endcase
      case (phase % 3)
         0: write_reg(CSR_INV_DEBYE, 20'd0);
         1: write_reg(CSR_INV_DEBYE, 20'hFFFFF);
         default: write_reg(CSR_INV_DEBYE, $urandom_range(65535));
      endcase
      write_reg(CSR_INV_EPS, (phase % 2) ? 24'hFFFFFF : $urandom_range(24'hFFFFFF));
   endtask

   // Half the points close to a charge, a quarter anywhere on the grid, the rest anywhere in the index range
   function automatic int near_index(input int grid_idx);
      int v;
      v = grid_idx + $urandom_range(6) - 3;
      return (v < 0) ? 0 : v;
   endfunction

   task automatic random_point();
      int sel;
      sel = $urandom_range(3);
      if (sel == 0)
         send_point(near_index(plus_cell[0]), near_index(plus_cell[1]),
                    near_index(plus_cell[2]));
      else if (sel == 1)
         send_point(near_index(minus_cell[0]), near_index(minus_cell[1]),
                    near_index(minus_cell[2]));
      else if (sel == 2)
         send_point($urandom_range(GRID_SIZE - 1), $urandom_range(GRID_SIZE - 1),
                    $urandom_range(GRID_SIZE - 1));
      else
         send_point($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
   endtask

   initial begin
      int c [3];
      reset       = 1'b1;
      idle_pct    = 0;
      stall_pct   = 0;
      hold_req    = 1'b0;
      points_sent = 0;
      config_writes = 0;
      req.valid   <= 1'b0;
      req.index_x <= '0;
      req.index_y <= '0;
      req.index_z <= '0;
      csr.valid   <= 1'b0;
      csr.index   <= '0;
      csr.data    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults: charges zero, centers at the origin
      send_point(0, 0, 0);
      send_point(1023, 1023, 1023);
      drain();

      // Opposite full-scale charges, plus center on grid point (0,0,0)
      c = '{256, 256, 256};
      write_reg(CSR_PLUS_CENTER, pack_center(c));
      c = '{-524288, 524287, 0};
      write_reg(CSR_MINUS_CENTER, pack_center(c));
      write_reg(CSR_PLUS_CHARGE, 24'h7FFFFF);
      write_reg(CSR_MINUS_CHARGE, 24'h800000);
      write_reg(CSR_INV_EPS, 24'hFFFFFF);
      send_point(0, 0, 0);       // zero distance, positive charge
      send_point(1, 0, 0);       // one grid step from the positive charge
      send_point(255, 255, 255);
      send_point(256, 300, 1023); // indices past the grid edge
      send_point(682, 341, 0);
      drain();
      write_reg(CSR_PLUS_CHARGE, 24'h800000);
      send_point(0, 0, 0);       // zero distance, negative charge
      send_point(0, 1, 0);
      send_point(0, 0, 2);
      drain();

      // Screened, grid scale extremes and zero, unmapped index
      write_reg(CSR_INV_DEBYE, 20'hFFFFF);
      write_reg(CSR_UNMAPPED, {CSR_DATA_W{1'b1}});
      send_point(3, 0, 0);
      send_point(0, 7, 9);
      drain();
      write_reg(CSR_INV_DEBYE, 20'h00100);
      write_reg(CSR_INV_GRID, 20'hFFFFF);
      send_point(5, 5, 5);
      send_point(100, 50, 20);
      drain();
      write_reg(CSR_INV_GRID, 20'd0);
      write_reg(CSR_INV_EPS, 24'd0);
      send_point(10, 20, 30);
      send_point(200, 100, 0);
      drain();
      write_reg(CSR_INV_GRID, 20'd1);
      write_reg(CSR_INV_EPS, 24'd209715);
      send_point(0, 1, 1);
      send_point(128, 128, 128);
      drain();

      // Random phases across idle modes and settings
      for (int phase = 0; phase < 8; phase++) begin
         random_settings(phase);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 17; stall_pct = 17; end
         endcase
         if (phase == 4) begin
            // Long result hold-off while points keep coming
            idle_pct = 0;
            hold_req = 1'b1;
         end
         for (int i = 0; i < 104; i++) random_point();
         drain();
      end

      $display("Covered %0d grid points under %0d register writes,", points_sent,
               config_writes);
      $display("with charge, distance and screening extremes and back-pressure.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: dipole_screened_boundary_potential_core.f
sv/dsbp_pkg.sv
sv/dsbp_chan_if.sv
sv/dsbp_term.sv
sv/dipole_screened_boundary_potential_core.sv
sv/dsbp_checker.sv
bench/dsbp_potential_checker.sv
bench/dipole_screened_boundary_potential_core_test.sv
